// File: sv/b64d_pkg.sv
// Shared types, codes and the alphabet lookup for the Base64 stream decoder.
// No dependencies; every other file of the block imports this package.
package b64d_pkg;

    localparam int QDEPTH  = 4;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCNT_W  = QAW + 1;

    localparam int ACC_W   = 18;
    localparam int FULL_W  = 24;

    localparam logic [6:0] CODE_PAD = 7'd64;
    localparam logic [6:0] CODE_BAD = 7'd65;

    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;

    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       message_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_error;
        logic       run_end;
        logic       message_end;
    } out_item_t;

    // One decoded group or one error, as queued between front and back
    typedef struct packed {
        logic [FULL_W-1:0] bytes;     // byte 0 in the top eight bits
        logic [1:0]        count;     // results to emit, 1 to 3
        logic              is_error;
        logic              msg_last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = 7'(c - 8'h30 + 8'd52);
        end else if (c == CHAR_PLUS) begin
            r = 7'd62;
        end else if (c == CHAR_SLASH) begin
            r = 7'd63;
        end else if (c == CHAR_EQ) begin
            r = CODE_PAD;
        end else begin
            r = CODE_BAD;
        end
        return r;
    endfunction

endpackage

// File: sv/b64d_front.sv
// Front end: accepts characters, classifies them and keeps the group state.
// Depends on b64d_pkg; pushes one job per completed group or error.
module b64d_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  b64d_pkg::in_item_t in_data,
    input  b64d_pkg::q_status_t q_status,
    output logic              push,
    output b64d_pkg::job_t    push_job
);
    import b64d_pkg::*;

    logic [ACC_W-1:0]  sextet_accum_reg, sextet_accum_next;
    logic [1:0]        quad_position_reg, quad_position_next;
    logic [1:0]        pad_count_reg, pad_count_next;
    logic              padding_done_reg, padding_done_next;
    logic              error_latched_reg, error_latched_next;

    logic              accept;
    logic              emit;
    logic [6:0]        code;
    logic [5:0]        val;
    logic              is_pad;
    logic              char_err;
    logic              len_err;
    logic [FULL_W-1:0] full;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && emit;

    always_comb
    begin
        code   = sextet_of(in_data.char_code);
        is_pad = (code == CODE_PAD);
        val    = is_pad ? 6'd0 : code[5:0];
        full   = {sextet_accum_reg, val};

        sextet_accum_next  = sextet_accum_reg;
        quad_position_next = quad_position_reg;
        pad_count_next     = pad_count_reg;
        padding_done_next  = padding_done_reg;
        error_latched_next = error_latched_reg;

        emit     = 1'b0;
        len_err  = 1'b0;
        char_err = (code == CODE_BAD) || padding_done_reg ||
                   (is_pad && quad_position_reg < POS_THIRD) ||
                   (!is_pad && quad_position_reg == POS_FOURTH && pad_count_reg != 2'd0);

        push_job          = '0;
        push_job.msg_last = in_data.message_last;

        if (error_latched_reg) begin
            // swallow until the message closes
            if (in_data.message_last) begin
                error_latched_next = 1'b0;
                sextet_accum_next  = '0;
                quad_position_next = '0;
                pad_count_next     = '0;
                padding_done_next  = 1'b0;
            end
        end else begin
            if (!char_err) begin
                pad_count_next = pad_count_reg + {1'b0, is_pad};
                if (quad_position_reg != POS_FOURTH) begin
                    sextet_accum_next  = full[ACC_W-1:0];
                    quad_position_next = quad_position_reg + 2'd1;
                    len_err            = in_data.message_last;
                end else begin
                    emit           = 1'b1;
                    push_job.bytes = full;
                    unique case (pad_count_next)
                        2'd0:    push_job.count = 2'd3;
                        2'd1:    push_job.count = 2'd2;
                        default: push_job.count = 2'd1;
                    endcase
                    padding_done_next  = !in_data.message_last && (pad_count_next != 2'd0);
                    sextet_accum_next  = '0;
                    quad_position_next = '0;
                    pad_count_next     = '0;
                end
            end
            if (char_err || len_err) begin
                emit               = 1'b1;
                push_job.bytes     = '0;
                push_job.count     = 2'd1;
                push_job.is_error  = 1'b1;
                sextet_accum_next  = '0;
                quad_position_next = '0;
                pad_count_next     = '0;
                padding_done_next  = 1'b0;
                error_latched_next = !in_data.message_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sextet_accum_reg  <= '0;
            quad_position_reg <= '0;
            pad_count_reg     <= '0;
            padding_done_reg  <= 1'b0;
            error_latched_reg <= 1'b0;
        end else if (accept) begin
            sextet_accum_reg  <= sextet_accum_next;
            quad_position_reg <= quad_position_next;
            pad_count_reg     <= pad_count_next;
            padding_done_reg  <= padding_done_next;
            error_latched_reg <= error_latched_next;
        end
    end

endmodule

// File: sv/b64d_queue.sv
// Short job queue between the front end and the output sequencer.
// Depends on b64d_pkg for the job type and depth constants.
module b64d_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64d_pkg::job_t     push_job,
    input  logic               pop,
    output b64d_pkg::job_t     head_job,
    output b64d_pkg::q_status_t q_status
);
    import b64d_pkg::*;

    job_t              mem [QDEPTH];
    logic [QAW-1:0]    wr_ptr_reg;
    logic [QAW-1:0]    rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;

    assign q_status.full  = (fill_reg == QCNT_W'(QDEPTH));
    assign q_status.empty = (fill_reg == '0);
    assign head_job       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// File: sv/b64d_back.sv
// Output sequencer: walks the head job one result per transfer.
// Depends on b64d_pkg; pops the queue after the job's last result.
module b64d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  b64d_pkg::q_status_t q_status,
    input  b64d_pkg::job_t      head_job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output b64d_pkg::out_item_t out_data
);
    import b64d_pkg::*;

    logic [1:0] k_reg, k_next;
    logic       last_one;
    logic       xfer;

    assign out_valid = !q_status.empty;
    assign xfer      = out_valid && out_ready;
    assign last_one  = (k_reg == head_job.count - 2'd1);
    assign pop       = xfer && last_one;

    always_comb
    begin
        unique case (k_reg)
            2'd0:    out_data.data_byte = head_job.bytes[23:16];
            2'd1:    out_data.data_byte = head_job.bytes[15:8];
            2'd2:    out_data.data_byte = head_job.bytes[7:0];
            default: out_data.data_byte = 8'd0;
        endcase
        out_data.is_error    = head_job.is_error;
        out_data.run_end     = last_one;
        out_data.message_end = last_one && head_job.msg_last;

        k_next = k_reg;
        if (xfer) begin
            k_next = last_one ? 2'd0 : k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            k_reg <= '0;
        end else begin
            k_reg <= k_next;
        end
    end

endmodule

// File: sv/base64_stream_decoder.sv
// Top level of the Base64 stream decoder: front end, job queue, sequencer.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// Usage
//   Input channel (in_valid/in_ready/in_data) takes one character per
//   transfer with a last-of-message flag. Output channel (out_valid/
//   out_ready/out_data) gives one result per transfer: a decoded byte, or
//   a single error result after which input is dropped until the message
//   closes. run_end marks the last result of a group or error, message_end the
//   result that closes the message.
//   Throughput: one character per cycle while the queue has room, one
//   result per cycle while out_ready is high. A group of four characters
//   yields at most three results, so a willing receiver never throttles
//   the input. The group state update in the front end sets this rate.
//   Output path: a group's job is registered in the four-entry job
//   queue, which serves as the output register; its first result appears
//   once the jobs queued ahead of it are out.
//   Receiver stall: the queue absorbs up to four pending jobs; when it
//   fills, in_ready drops until the sequencer frees an entry.
//   Reset: rst_n clears group state, queue pointers and the sequencer;
//   the block accepts characters as soon as reset is released.
module base64_stream_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  b64d_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output b64d_pkg::out_item_t out_data
);
    import b64d_pkg::*;

    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      head_job;
    q_status_t q_status;

    // classify characters and build jobs
    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    // decouple the two sides
    b64d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    // emit results one transfer at a time
    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_job  (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: sv/b64d_checker.sv
// Port-level checks for the Base64 stream decoder, bound to the top level.
// Depends on b64d_pkg for the payload types.
module b64d_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input b64d_pkg::out_item_t out_data
);
    import b64d_pkg::*;

    // a stalled result holds until it transfers
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // an error result carries no byte and closes its run
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_error |-> out_data.data_byte == 8'd0 && out_data.run_end)
        else $error("malformed error result");

    a_msg_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.message_end |-> out_data.run_end)
        else $error("message end without run end");

    // an edge taken in reset leaves the block empty and ready
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid && in_ready)
        else $error("activity during reset");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);

// File: dv/tb_base64_stream_decoder.sv
// Self-checking testbench for base64_stream_decoder: directed and random messages.
// Depends on b64d_pkg and the decoder RTL; drives both valid/ready channels and
// checks every transfer against a cycle-free model of the decoder.
module tb_base64_stream_decoder;
    import b64d_pkg::*;

    localparam int CHAR_TARGET = 470;   // directed plus random characters
    localparam int DRAIN_MARK  = 260;   // second full drain near mid-run
    localparam int TAIL_CYCLES = 20;

    typedef enum int {
        MSG_CLEAN,
        MSG_BAD_CHAR,
        MSG_EARLY_PAD,
        MSG_SHORT,
        MSG_AFTER_PAD,
        MSG_NOISE
    } msg_kind_e;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_THIRD,
        RX_CHOKE
    } rx_mode_e;

    // One classified character: alphabet sextet, pad or outside the alphabet
    typedef struct packed {
        logic       bad;
        logic       pad;
        logic [5:0] value;
    } sym_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // Stimulus waiting to be driven, and results still owed by the decoder
    in_item_t  char_queue[$];
    out_item_t predicted_out[$];
    int        drain_at[$];
    logic [7:0] msg_chars[$];

    // Decoder state as the model tracks it
    logic [17:0] group_bits  = '0;
    logic [1:0]  group_pos   = '0;
    logic [1:0]  group_pads  = '0;
    logic        pad_closed  = 1'b0;
    logic        dropping    = 1'b0;

    int mismatches    = 0;
    int chars_sent    = 0;
    int items_offered = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int bytes_seen    = 0;
    int faults_seen   = 0;
    int closes_seen   = 0;

    rx_mode_e  rx_mode   = RX_OPEN;
    int        mode_left = 0;
    int        hold_left = 0;
    out_item_t got_now;
    out_item_t want_now;

    base64_stream_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of the decoder
    // ------------------------------------------------------------------

    function automatic sym_t classify_char(input logic [7:0] c);
        sym_t s;
        s = '0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            s.value = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            s.value = 6'(c - 8'h47);      // lower case starts at sextet 26
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            s.value = 6'(c + 8'd4);       // digits start at sextet 52
        end
        else if (c == CHAR_PLUS)
        begin
            s.value = 6'd62;
        end
        else if (c == CHAR_SLASH)
        begin
            s.value = 6'd63;
        end
        else if (c == CHAR_EQ)
        begin
            s.pad = 1'b1;
        end
        else
        begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

    task automatic clear_group();
        group_bits = '0;
        group_pos  = '0;
        group_pads = '0;
        pad_closed = 1'b0;
        dropping   = 1'b0;
    endtask

    task automatic owe_result(input logic [7:0] b, input logic err, input logic rend,
                              input logic mend);
        out_item_t r;
        r.data_byte   = b;
        r.is_error    = err;
        r.run_end     = rend;
        r.message_end = mend;
        predicted_out.push_back(r);
    endtask

    // Advance the model by one accepted character; queue the results it owes
    task automatic decode_char(input in_item_t it);
        sym_t        s;
        logic        fault;
        logic [5:0]  sextet;
        logic [23:0] group_word;
        int          nbytes;
        s = classify_char(it.char_code);
        if (dropping)
        begin
            if (it.message_last)
                clear_group();
            return;
        end
        fault = s.bad || pad_closed || (s.pad && group_pos < POS_THIRD) ||
                (!s.bad && !s.pad && group_pos == POS_FOURTH && group_pads != 2'd0);
        if (!fault)
        begin
            sextet = s.pad ? 6'd0 : s.value;
            if (s.pad)
                group_pads = group_pads + 2'd1;
            if (group_pos != POS_FOURTH)
            begin
                group_bits = {group_bits[11:0], sextet};
                group_pos  = group_pos + 2'd1;
                if (!it.message_last)
                    return;
                fault = 1'b1;             // message closed mid-group
            end
            else
            begin
                group_word = {group_bits, sextet};
                nbytes = 3 - ((group_pads > 2'd2) ? 2 : int'(group_pads));
                for (int k = 0; k < nbytes; k++)
                    owe_result(group_word[23 - 8 * k -: 8], 1'b0, k == nbytes - 1,
                               (k == nbytes - 1) && it.message_last);
                if (it.message_last)
                begin
                    clear_group();
                end
                else
                begin
                    pad_closed = (group_pads != 2'd0);
                    group_bits = '0;
                    group_pos  = '0;
                    group_pads = '0;
                end
                return;
            end
        end
        owe_result(8'd0, 1'b1, 1'b1, it.message_last);
        clear_group();
        if (!it.message_last)
            dropping = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 6'd26)
            return 8'h41 + 8'(v);
        if (v < 6'd52)
            return 8'h61 + 8'(v - 6'd26);
        if (v < 6'd62)
            return 8'h30 + 8'(v - 6'd52);
        return (v == 6'd62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    task automatic queue_char(input logic [7:0] c, input logic last);
        in_item_t it;
        it.char_code    = c;
        it.message_last = last;
        char_queue.push_back(it);
    endtask

    task automatic queue_text(input string s, input logic close);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], close && (i == s.len() - 1));
    endtask

    // Append whole groups of random sextets; pad the last group with npads '='
    task automatic add_groups(input int ngroups, input int npads);
        for (int g = 0; g < ngroups; g++)
            for (int p = 0; p < 4; p++)
                if (g == ngroups - 1 && p >= 4 - npads)
                    msg_chars.push_back(CHAR_EQ);
                else
                    msg_chars.push_back(sextet_char(6'($urandom_range(0, 63))));
    endtask

    task automatic flush_message();
        for (int i = 0; i < msg_chars.size(); i++)
            queue_char(msg_chars[i], i == msg_chars.size() - 1);
        msg_chars.delete();
    endtask

    // ------------------------------------------------------------------
    // Input driver: bursts with random gaps, full drains at marked points
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_char(in_data);
                chars_sent++;
            end
            if (in_valid && !in_ready)
            begin
                // hold the pending transfer unchanged
            end
            else if (drain_at.size() != 0 && items_offered == drain_at[0])
            begin
                // hold off until every owed result has come out
                in_valid <= 1'b0;
                if (predicted_out.size() == 0)
                    drain_at.pop_front();
            end
            else if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (char_queue.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= char_queue.pop_front();
                items_offered++;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stall pattern: switch among open, coin-flip, periodic
    // and long choke windows
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 200);
                hold_left = 0;
            end
            else
            begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN:  out_ready <= 1'b1;
                RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
                RX_THIRD: out_ready <= (mode_left % 3 == 0);
                default:
                begin
                    if (hold_left == 0)
                        hold_left = $urandom_range(4, 15);
                    out_ready <= (hold_left <= 2);
                    hold_left--;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each output transfer with the oldest owed result
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_now = out_data;
            if (got_now.is_error)
                faults_seen++;
            else
                bytes_seen++;
            if (got_now.message_end)
                closes_seen++;
            if (predicted_out.size() == 0)
            begin
                $error("unexpected result: data_byte %0h is_error %0b run_end %0b message_end %0b",
                       got_now.data_byte, got_now.is_error, got_now.run_end,
                       got_now.message_end);
                mismatches++;
            end
            else
            begin
                want_now = predicted_out.pop_front();
                if (got_now.data_byte !== want_now.data_byte)
                begin
                    $error("data_byte: expected %0h, got %0h",
                           want_now.data_byte, got_now.data_byte);
                    mismatches++;
                end
                if (got_now.is_error !== want_now.is_error)
                begin
                    $error("is_error: expected %0b, got %0b",
                           want_now.is_error, got_now.is_error);
                    mismatches++;
                end
                if (got_now.run_end !== want_now.run_end)
                begin
                    $error("run_end: expected %0b, got %0b",
                           want_now.run_end, got_now.run_end);
                    mismatches++;
                end
                if (got_now.message_end !== want_now.message_end)
                begin
                    $error("message_end: expected %0b, got %0b",
                           want_now.message_end, got_now.message_end);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------

    initial
    begin
        int        pick;
        int        ngroups;
        msg_kind_e kind;

        // Directed: full groups with '+', '/' and digit bounds, single and
        // double pad, data after a pad, pad too early, a byte outside the
        // alphabet, a short message and data after a padded group.
        queue_text("+/90", 1'b0);
        queue_text("QUI=", 1'b1);
        queue_text("Zg==", 1'b1);
        queue_text("AB=C", 1'b1);
        queue_text("A=", 1'b0);
        queue_text("z", 1'b1);
        queue_text("=", 1'b1);
        queue_char(8'hFF, 1'b1);
        queue_text("Zm9", 1'b1);
        queue_text("Zg==", 1'b0);
        queue_text("A", 1'b1);
        drain_at.push_back(char_queue.size());

        // Random: mostly well-formed messages, the rest broken or noise
        while (char_queue.size() < CHAR_TARGET)
        begin
            pick    = $urandom_range(0, 99);
            ngroups = $urandom_range(1, 5);
            kind    = (pick < 60) ? MSG_CLEAN :
                      (pick < 68) ? MSG_BAD_CHAR :
                      (pick < 76) ? MSG_EARLY_PAD :
                      (pick < 84) ? MSG_SHORT :
                      (pick < 92) ? MSG_AFTER_PAD : MSG_NOISE;
            case (kind)
                MSG_CLEAN:
                    add_groups(ngroups, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 2));
                MSG_BAD_CHAR:
                begin
                    add_groups(ngroups, 0);
                    msg_chars[$urandom_range(0, msg_chars.size() - 1)] =
                        8'($urandom_range(0, 255));
                end
                MSG_EARLY_PAD:
                begin
                    add_groups(ngroups, 0);
                    msg_chars[4 * $urandom_range(0, ngroups - 1) + $urandom_range(0, 1)] =
                        CHAR_EQ;
                end
                MSG_SHORT:
                begin
                    add_groups(ngroups, 0);
                    repeat ($urandom_range(1, 3))
                        void'(msg_chars.pop_back());
                end
                MSG_AFTER_PAD:
                begin
                    add_groups(1, $urandom_range(1, 2));
                    add_groups($urandom_range(1, 2), 0);
                end
                default:
                    repeat ($urandom_range(1, 8))
                        msg_chars.push_back(8'($urandom_range(0, 255)));
            endcase
            flush_message();
            if (drain_at.size() < 2 && char_queue.size() >= DRAIN_MARK)
                drain_at.push_back(char_queue.size());
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every character to transfer and every result to drain
        while (char_queue.size() != 0 || in_valid || predicted_out.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Run covered %0d characters, %0d messages closed on the output side,",
                 chars_sent, closes_seen);
        $display("%0d decoded bytes and %0d error results, with random gaps and stalls.",
                 bytes_seen, faults_seen);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: base64_stream_decoder.f
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder.sv
sv/b64d_checker.sv
dv/tb_base64_stream_decoder.sv
